@@ hdl/hnl_pkg.sv @@
`default_nettype none
package hnl_pkg;

  typedef struct packed {
    logic [6:0] pitch;
    logic [6:0] velocity;
  } entry_t;

  typedef struct packed {
    logic ins;
    logic shift;
    logic wrap;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PASS,
    ST_FLUSH
  } state_t;

  localparam logic MODE_VELOCITY = 1'b0;
  localparam logic MODE_PITCH    = 1'b1;

endpackage
`default_nettype wire

@@ hdl/held_note_list.sv @@
`default_nettype none
// channel  | ports                                          | handshake
// ---------+------------------------------------------------+------------------------
// input    | mode, value                                    | start && !busy
// result   | pitch, velocity, last, empty_res, dropped      | strobe, one cycle each
//
// a velocity word is taken while the list stays idle; a pitch word runs a pass over n
// entries, n being those held after a note-on, or before a note-off, and then a flush
// each pass cycle moves the head cell out and rotates it to the tail, dropping the
// first matching entry on note-off
// a kept entry is held in pend after passing the head and leaves as a result when the
// next kept entry passes; the final word, or the empty word, comes from the flush cycle
// rst is synchronous and empties the list; the receiver cannot stall, so
// busy depends on the pass and the flush alone
module held_note_list #(
  parameter int MAX_HELD = 16
) (
  input  wire       clk,
  input  wire       rst,
  input  wire       start,
  output logic      busy,
  input  wire       mode,
  input  wire [6:0] value,
  output logic      strobe,
  output logic [6:0] pitch,
  output logic [6:0] velocity,
  output logic      last,
  output logic      empty_res,
  output logic      dropped
);
  import hnl_pkg::*;

  localparam int CW = $clog2(MAX_HELD + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_HELD);

  state_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] pass_left;
  logic [6:0]    cur_vel;
  logic [6:0]    key;
  logic          del_en;
  logic          drop;
  entry_t        pend;
  logic          pend_valid;

  entry_t     cells [MAX_HELD];
  entry_t     head;
  entry_t     new_entry;
  cell_ctrl_t ctrl;
  logic [MAX_HELD-1:0] tail_hit;
  logic [MAX_HELD-1:0] ins_hit;

  logic accept;
  logic pass_act;
  logic is_rm;
  logic keep;
  logic do_ins;
  logic emit;
  logic emit_last;
  logic emit_empty;
  entry_t emit_entry;

  assign accept   = start && (state == ST_IDLE);
  assign head     = cells[0];
  assign pass_act = (state == ST_PASS) && (pass_left != '0);
  assign is_rm    = pass_act && del_en && (head.pitch == key);
  assign keep     = pass_act && !is_rm;
  assign do_ins   = accept && (mode == MODE_PITCH) && (cur_vel != 7'd0) && (count != FULL);

  assign new_entry.pitch    = value;
  assign new_entry.velocity = cur_vel;

  assign ctrl.ins   = do_ins;
  assign ctrl.shift = pass_act;
  assign ctrl.wrap  = keep;

  for (genvar g = 0; g < MAX_HELD; g++) begin : g_cell
    assign tail_hit[g] = (count == CW'(g + 1));
    assign ins_hit[g]  = (count == CW'(g));
    if (g == MAX_HELD - 1) begin : g_end
      hnl_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .tail_hit  (tail_hit[g]),
        .ins_hit   (ins_hit[g]),
        .head      (head),
        .right     (cells[g]),
        .new_entry (new_entry),
        .q         (cells[g])
      );
    end else begin : g_mid
      hnl_cell u_cell (
        .clk       (clk),
        .ctrl      (ctrl),
        .tail_hit  (tail_hit[g]),
        .ins_hit   (ins_hit[g]),
        .head      (head),
        .right     (cells[g+1]),
        .new_entry (new_entry),
        .q         (cells[g])
      );
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (mode == MODE_PITCH)) state_next = ST_PASS;
      end
      ST_PASS: begin
        if (pass_left == '0) state_next = ST_FLUSH;
      end
      ST_FLUSH: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // result word
  always_comb begin
    emit       = 1'b0;
    emit_last  = 1'b0;
    emit_empty = 1'b0;
    emit_entry = pend;
    unique case (state)
      ST_PASS: begin
        emit = keep && pend_valid;
      end
      ST_FLUSH: begin
        emit      = 1'b1;
        emit_last = 1'b1;
        if (!pend_valid) begin
          emit_empty = 1'b1;
          emit_entry = '0;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  assign busy = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      cur_vel    <= 7'd0;
      strobe     <= 1'b0;
      pend_valid <= 1'b0;
      del_en     <= 1'b0;
      pass_left  <= '0;
    end else begin
      state  <= state_next;
      strobe <= emit;
      if (accept) begin
        if (mode == MODE_VELOCITY) begin
          cur_vel <= value;
        end else begin
          key        <= value;
          del_en     <= (cur_vel == 7'd0);
          drop       <= (cur_vel != 7'd0) && (count == FULL);
          pend_valid <= 1'b0;
          count      <= count + CW'(do_ins);
          pass_left  <= count + CW'(do_ins);
        end
      end else if (pass_act) begin
        pass_left <= pass_left - CW'(1);
        if (is_rm) begin
          del_en <= 1'b0;
          count  <= count - CW'(1);
        end
        if (keep) begin
          pend       <= head;
          pend_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pitch     <= emit_entry.pitch;
      velocity  <= emit_entry.velocity;
      last      <= emit_last;
      empty_res <= emit_empty;
      dropped   <= drop;
    end
  end

endmodule
`default_nettype wire

@@ hdl/hnl_cell.sv @@
`default_nettype none
module hnl_cell (
  input  wire                      clk,
  input  wire hnl_pkg::cell_ctrl_t ctrl,
  input  wire                      tail_hit,
  input  wire                      ins_hit,
  input  wire hnl_pkg::entry_t     head,
  input  wire hnl_pkg::entry_t     right,
  input  wire hnl_pkg::entry_t     new_entry,
  output hnl_pkg::entry_t          q
);
  import hnl_pkg::*;

  entry_t data;

  always_ff @(posedge clk) begin
    if (ctrl.ins && ins_hit) begin
      data <= new_entry;
    end else if (ctrl.shift) begin
      if (ctrl.wrap && tail_hit) begin
        data <= head;
      end else begin
        data <= right;
      end
    end
  end

  assign q = data;

endmodule
`default_nettype wire

@@ test/held_note_list_tb.sv @@
`timescale 1ns / 100ps
module held_note_list_tb;
  import hnl_pkg::*;

  localparam int MAX_HELD = 16;
  localparam int TOTAL_WORDS = 260;
  localparam int CYCLE_LIMIT = 200000;

  typedef struct {
    logic       mode;
    logic [6:0] value;
    bit         drain;
  } note_event_t;

  typedef struct {
    logic [6:0] pitch;
    logic [6:0] velocity;
    logic       last;
    logic       empty_res;
    logic       dropped;
  } listing_word_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       mode;
  logic [6:0] value;
  logic       strobe;
  logic [6:0] pitch;
  logic [6:0] velocity;
  logic       last;
  logic       empty_res;
  logic       dropped;

  note_event_t   note_events[$];
  listing_word_t listing_due[$];

  // predictor state
  logic [6:0] held_p[MAX_HELD];
  logic [6:0] held_v[MAX_HELD];
  int         held_n;
  logic [6:0] cur_vel;

  // stimulus shadow
  logic [6:0] gen_vel;
  logic [6:0] gen_pitches[$];

  int mismatches;
  int cycles;
  int gap_left;
  int burst_left;
  bit taken;

  held_note_list #(
    .MAX_HELD(MAX_HELD)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .mode(mode),
    .value(value),
    .strobe(strobe),
    .pitch(pitch),
    .velocity(velocity),
    .last(last),
    .empty_res(empty_res),
    .dropped(dropped)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  task automatic report_fault(input string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [6:0] got, input logic [6:0] want);
    if (got !== want) begin
      report_fault($sformatf("%s got %0d, want %0d", name, got, want));
    end
  endtask

  task automatic track_held_notes(input logic m, input logic [6:0] v);
    logic          drop;
    int            idx;
    listing_word_t w;
    drop = 1'b0;
    if (m == MODE_VELOCITY) begin
      cur_vel = v;
    end else begin
      if (cur_vel != 7'd0) begin
        if (held_n < MAX_HELD) begin
          held_p[held_n] = v;
          held_v[held_n] = cur_vel;
          held_n++;
        end else begin
          drop = 1'b1;
        end
      end else begin
        idx = -1;
        for (int i = 0; i < held_n; i++) begin
          if (idx < 0 && held_p[i] == v) idx = i;
        end
        if (idx >= 0) begin
          for (int i = idx; i < held_n - 1; i++) begin
            held_p[i] = held_p[i + 1];
            held_v[i] = held_v[i + 1];
          end
          held_n--;
        end
      end
      if (held_n == 0) begin
        w.pitch = 7'd0;
        w.velocity = 7'd0;
        w.last = 1'b1;
        w.empty_res = 1'b1;
        w.dropped = drop;
        listing_due.push_back(w);
      end else begin
        for (int i = 0; i < held_n; i++) begin
          w.pitch = held_p[i];
          w.velocity = held_v[i];
          w.last = (i == held_n - 1);
          w.empty_res = 1'b0;
          w.dropped = drop;
          listing_due.push_back(w);
        end
      end
    end
  endtask

  task automatic queue_event(input logic m, input logic [6:0] v, input bit drain);
    note_event_t e;
    int          idx;
    e.mode = m;
    e.value = v;
    e.drain = drain;
    note_events.push_back(e);
    if (m == MODE_VELOCITY) begin
      gen_vel = v;
    end else if (gen_vel != 7'd0) begin
      if (gen_pitches.size() < MAX_HELD) gen_pitches.push_back(v);
    end else begin
      idx = -1;
      foreach (gen_pitches[i]) begin
        if (idx < 0 && gen_pitches[i] == v) idx = i;
      end
      if (idx >= 0) gen_pitches.delete(idx);
    end
  endtask

  // driver
  always @(negedge clk) begin : drive_words
    note_event_t e;
    if (!rst) begin
      if (start && !taken) begin
        // hold the word until it is taken
      end else if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (note_events.size() > 0 &&
                   !(note_events[0].drain && listing_due.size() != 0)) begin
        e = note_events.pop_front();
        start <= 1'b1;
        mode <= e.mode;
        value <= e.value;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
          gap_left <= 0;
        end else if ($urandom_range(0, 99) < 5) begin
          burst_left <= $urandom_range(10, 30);
          gap_left <= 0;
        end else begin
          case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: gap_left <= 0;
            5, 6, 7, 8:    gap_left <= $urandom_range(1, 4);
            default:       gap_left <= $urandom_range(10, 45);
          endcase
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin : watch_words
    listing_word_t want;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("== FAIL ==");
      $finish;
    end
    taken = !rst && start && !busy;
    if (!rst && strobe) begin
      if (listing_due.size() == 0) begin
        report_fault($sformatf("word with nothing due: pitch %0d velocity %0d", pitch, velocity));
      end else begin
        want = listing_due.pop_front();
        check_field("pitch", pitch, want.pitch);
        check_field("velocity", velocity, want.velocity);
        check_field("last", 7'(last), 7'(want.last));
        check_field("empty_res", 7'(empty_res), 7'(want.empty_res));
        check_field("dropped", 7'(dropped), 7'(want.dropped));
      end
    end
    if (taken) track_held_notes(mode, value);
  end

  initial begin
    bit         filling;
    bit         note_on;
    int         r;
    logic [6:0] p;
    rst = 1'b1;
    start = 1'b0;
    mode = MODE_VELOCITY;
    value = 7'd0;
    held_n = 0;
    cur_vel = 7'd0;
    gen_vel = 7'd0;
    mismatches = 0;
    cycles = 0;
    gap_left = 0;
    burst_left = 0;
    taken = 1'b0;

    // directed: empty no-match, extremes, duplicates, full list, head removal
    queue_event(MODE_PITCH, 7'd60, 1'b0);
    queue_event(MODE_VELOCITY, 7'd127, 1'b0);
    queue_event(MODE_PITCH, 7'd127, 1'b0);
    queue_event(MODE_VELOCITY, 7'd1, 1'b0);
    queue_event(MODE_PITCH, 7'd0, 1'b0);
    queue_event(MODE_PITCH, 7'd127, 1'b0);
    queue_event(MODE_VELOCITY, 7'd42, 1'b0);
    for (int i = 0; i < MAX_HELD - 3; i++) begin
      queue_event(MODE_PITCH, 7'(7 * i + 10), 1'b0);
    end
    queue_event(MODE_PITCH, 7'd99, 1'b0);
    queue_event(MODE_VELOCITY, 7'd0, 1'b0);
    queue_event(MODE_PITCH, 7'd127, 1'b0);
    queue_event(MODE_PITCH, 7'd5, 1'b0);
    queue_event(MODE_PITCH, 7'd0, 1'b1);

    // random: mostly note-on / note-off pairs, some noise
    filling = 1'b1;
    r = 0;
    while (note_events.size() < TOTAL_WORDS) begin
      if (gen_pitches.size() == 0) filling = 1'b1;
      else if (gen_pitches.size() == MAX_HELD && $urandom_range(0, 3) == 0) filling = 1'b0;
      else if ($urandom_range(0, 19) == 0) filling = !filling;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        queue_event(1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)),
                    $urandom_range(0, 39) == 0);
      end else begin
        note_on = filling ? (r < 75) : (r < 30);
        if (note_on) begin
          if (gen_vel == 7'd0 || $urandom_range(0, 9) < 4) begin
            queue_event(MODE_VELOCITY, 7'($urandom_range(1, 127)), 1'b0);
          end
          if (gen_pitches.size() > 0 && $urandom_range(0, 3) == 0)
            p = gen_pitches[$urandom_range(0, gen_pitches.size() - 1)];
          else
            p = 7'($urandom_range(0, 127));
        end else begin
          if (gen_vel != 7'd0) queue_event(MODE_VELOCITY, 7'd0, 1'b0);
          if (gen_pitches.size() > 0 && $urandom_range(0, 4) != 0)
            p = gen_pitches[$urandom_range(0, gen_pitches.size() - 1)];
          else
            p = 7'($urandom_range(0, 127));
        end
        queue_event(MODE_PITCH, p, note_events.size() == 25 || $urandom_range(0, 39) == 0);
      end
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;

    while (note_events.size() != 0 || start || listing_due.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && listing_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

@@ held_note_list.f @@
hdl/hnl_pkg.sv
hdl/hnl_cell.sv
hdl/held_note_list.sv
test/held_note_list_tb.sv
